// File: sv/gshp_pkg.sv
// shared types, constants and counter update for the gshare predictor
`default_nettype none
package gshp_pkg;

  localparam int PcWidth         = 64;
  localparam int IndexBitsDef    = 16;
  localparam int HistoryBitsDef  = 16;
  localparam int HistoryReset    = 16;

  typedef enum logic [1:0] {
    CTR_SN = 2'd0,
    CTR_WN = 2'd1,
    CTR_WT = 2'd2,
    CTR_ST = 2'd3
  } ctr_t;

  typedef struct packed {
    logic predicted_taken;
    logic mispredict;
  } result_t;

  function automatic ctr_t ctr_next(input ctr_t cur, input logic taken);
    logic pred;
    ctr_t nxt;
    pred = cur[1];
    if (pred == taken) begin
      nxt = pred ? CTR_ST : CTR_SN;
    end else begin
      unique case (cur)
        CTR_SN, CTR_WT: nxt = CTR_WN;
        CTR_ST, CTR_WN: nxt = CTR_WT;
        default:        nxt = CTR_WN;
      endcase
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

// File: sv/gshp_if.sv
// handshake channels for branch words and prediction result words
`default_nettype none
interface gshp_in_if;
  import gshp_pkg::*;
  logic               valid;
  logic               ready;
  logic [PcWidth-1:0] branch_pc;
  logic               taken;
  modport source (output valid, output branch_pc, output taken, input ready);
  modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface gshp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic mispredict;
  modport source (output valid, output predicted_taken, output mispredict, input ready);
  modport sink   (input valid, input predicted_taken, input mispredict, output ready);
endinterface
`default_nettype wire

// File: sv/gshp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module gshp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/gshare_branch_predictor.sv
// gshare predictor top level: index hash, table update, result queue
// accepted words are registered in the update stage; results then enter the result queue
// one branch word per cycle when in.ready is high, set by the single table read and write port
// same-index updates on consecutive words are forwarded from the last write
// reset: history loads 16 masked to its width; a clearing pass over all 2^INDEX_BITS
// entries then zeroes the pattern table, with in.ready low until it ends
`default_nettype none
module gshare_branch_predictor #(
  parameter int INDEX_BITS   = gshp_pkg::IndexBitsDef,
  parameter int HISTORY_BITS = gshp_pkg::HistoryBitsDef
) (
  input wire logic   clk,
  input wire logic   rst_n,
  gshp_in_if.sink    in_br,
  gshp_out_if.source out_res
);
  import gshp_pkg::*;

  localparam int Depth = 1 << INDEX_BITS;
  localparam logic [HISTORY_BITS-1:0] HistRst = HISTORY_BITS'(HistoryReset);
  localparam int QDepth = 3;

  logic                    in_acc;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic [INDEX_BITS-1:0]   rd_idx;

  logic                    clearing_r;
  logic [INDEX_BITS-1:0]   clr_addr_r;

  logic                    s1_v_r;
  logic [INDEX_BITS-1:0]   s1_idx_r;
  logic                    s1_taken_r;

  logic                    wl_v_r;
  logic [INDEX_BITS-1:0]   wl_idx_r;
  ctr_t                    wl_st_r;

  logic [1:0]              ram_rdata;
  ctr_t                    cur_st, new_st;
  result_t                 s1_res;

  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [1:0]              ram_wdata;

  result_t                 q_r [QDepth];
  logic [1:0]              q_wr_r, q_rd_r, q_cnt_r;
  logic                    q_pop;
  logic [2:0]              q_load;

  assign in_acc   = in_br.valid && in_br.ready;
  assign rd_idx   = in_br.branch_pc[INDEX_BITS-1:0] ^ INDEX_BITS'(hist_r);
  assign hist_nxt = HISTORY_BITS'({hist_r, in_br.taken});

  // history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= HistRst;
    end else if (in_acc) begin
      hist_r <= hist_nxt;
    end
  end

  // table clearing after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  gshp_ram #(
    .WIDTH (2),
    .DEPTH (Depth)
  ) u_pht (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // update stage
  always_comb begin
    cur_st = (wl_v_r && wl_idx_r == s1_idx_r) ? wl_st_r : ctr_t'(ram_rdata);
    new_st = ctr_next(cur_st, s1_taken_r);
    s1_res.predicted_taken = cur_st[1];
    s1_res.mispredict      = cur_st[1] ^ s1_taken_r;
  end

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = CTR_SN;
    end else begin
      ram_we    = s1_v_r;
      ram_waddr = s1_idx_r;
      ram_wdata = new_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wl_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      wl_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r   <= rd_idx;
      s1_taken_r <= in_br.taken;
    end
    wl_idx_r <= s1_idx_r;
    wl_st_r  <= new_st;
  end

  // result queue
  assign q_pop   = out_res.valid && out_res.ready;
  assign q_load  = {1'b0, q_cnt_r} + {2'b00, s1_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s1_v_r) begin
        q_wr_r <= (q_wr_r == 2'(QDepth - 1)) ? 2'd0 : q_wr_r + 2'd1;
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == 2'(QDepth - 1)) ? 2'd0 : q_rd_r + 2'd1;
      end
      q_cnt_r <= 2'(q_load - {2'b00, q_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      q_r[q_wr_r] <= s1_res;
    end
  end

  assign in_br.ready             = !clearing_r && (q_load < 3'(QDepth));
  assign out_res.valid           = (q_cnt_r != 2'd0);
  assign out_res.predicted_taken = q_r[q_rd_r].predicted_taken;
  assign out_res.mispredict      = q_r[q_rd_r].mispredict;

  // checks
  a_acc_reaches_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted word did not reach the update stage");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (q_cnt_r != 2'(QDepth)))
    else $error("result queue overflow");

  a_clear_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_addr_r) == '1))
    else $error("clearing pass ended early");

  a_no_acc_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |=> !s1_v_r)
    else $error("word accepted during clearing pass");

endmodule
`default_nettype wire
